// ===== rtl/grna_pkg.sv =====
// Shared types and constants for the gated nearest reflector association block.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package grna_pkg;

    localparam int MAP_DEPTH   = 64;
    localparam int IDX_W       = $clog2(MAP_DEPTH);
    localparam int CNT_W       = $clog2(MAP_DEPTH + 1);

    localparam int COORD_W     = 32;
    localparam int TRIG_W      = 16;
    localparam int BASE_W      = 31;
    localparam int SLOPE_W     = 16;
    localparam int QIDX_W      = 8;
    localparam int MAP_INDEX_W = 6;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 16;

    localparam int ROT_W       = 48;
    localparam int Q_W         = 35;
    localparam int DIFF_W      = 35;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int D2_W        = SQ_W + 1;
    localparam int RAD_W       = 64;
    localparam int RANGE_W     = 32;
    localparam int GATE_W      = 33;
    localparam int GATE2_W     = 2 * GATE_W;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int FRAC_TRIG   = 14;
    localparam int FRAC_SLOPE  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_REL_COS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_SIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_DX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_DY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd5;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  rel_cos;
        logic signed [TRIG_W-1:0]  rel_sin;
        logic signed [COORD_W-1:0] rel_dx;
        logic signed [COORD_W-1:0] rel_dy;
        logic [BASE_W-1:0]         base_threshold;
        logic [SLOPE_W-1:0]        range_slope;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic [GATE2_W-1:0]    gate2;
    } geom_t;

endpackage
`default_nettype wire

// ===== rtl/grna_cell.sv =====
// One map slot of the reflector ring: holds a point and passes it to its neighbor.
// Depends on grna_pkg.
`default_nettype none
module grna_cell (
    input  wire logic                               clk,
    input  wire logic                               shift_en,
    input  wire logic signed [grna_pkg::COORD_W-1:0] shift_x,
    input  wire logic signed [grna_pkg::COORD_W-1:0] shift_y,
    input  wire logic                               wr_en,
    input  wire logic signed [grna_pkg::COORD_W-1:0] wr_x,
    input  wire logic signed [grna_pkg::COORD_W-1:0] wr_y,
    output logic signed [grna_pkg::COORD_W-1:0]      x,
    output logic signed [grna_pkg::COORD_W-1:0]      y
);
    import grna_pkg::*;

    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= shift_x;
            y_reg <= shift_y;
        end
        else if (wr_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule
`default_nettype wire

// ===== rtl/grna_geom.sv =====
// Query geometry: map-frame transform, range square root and gate, on one shared multiplier.
// Depends on grna_pkg.
`default_nettype none
module grna_geom (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [grna_pkg::COORD_W-1:0] px,
    input  wire logic signed [grna_pkg::COORD_W-1:0] py,
    input  wire grna_pkg::cfg_t                      cfg,
    output logic                                     done,
    output grna_pkg::geom_t                          geom
);
    import grna_pkg::*;

    typedef enum logic [9:0] {
        G_IDLE = 10'b0000000001,
        G_ROT0 = 10'b0000000010,
        G_ROT1 = 10'b0000000100,
        G_ROT2 = 10'b0000001000,
        G_ROT3 = 10'b0000010000,
        G_SQ0  = 10'b0000100000,
        G_SQ1  = 10'b0001000000,
        G_ROOT = 10'b0010000000,
        G_GATE = 10'b0100000000,
        G_SQG  = 10'b1000000000
    } gstate_t;

    gstate_t                   state_reg, state_next;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [ROT_W-1:0]   acc_x_reg, acc_y_reg;
    logic [RAD_W-1:0]          rad_reg, root_reg, bit_reg;
    logic [GATE_W-1:0]         gate_reg;
    geom_t                     geom_reg;
    logic                      done_reg;

    logic [COORD_W-1:0]        ax, ay;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [RAD_W-1:0]          trial;

    assign ax    = px_reg[COORD_W-1] ? COORD_W'(-px_reg) : COORD_W'(px_reg);
    assign ay    = py_reg[COORD_W-1] ? COORD_W'(-py_reg) : COORD_W'(py_reg);
    assign trial = root_reg + bit_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            G_ROT0:
            begin
                mul_a = MUL_W'(cfg.rel_cos);
                mul_b = MUL_W'(px_reg);
            end
            G_ROT1:
            begin
                mul_a = MUL_W'(cfg.rel_sin);
                mul_b = MUL_W'(py_reg);
            end
            G_ROT2:
            begin
                mul_a = MUL_W'(cfg.rel_sin);
                mul_b = MUL_W'(px_reg);
            end
            G_ROT3:
            begin
                mul_a = MUL_W'(cfg.rel_cos);
                mul_b = MUL_W'(py_reg);
            end
            G_SQ0:
            begin
                mul_a = $signed({2'b00, ax});
                mul_b = $signed({2'b00, ax});
            end
            G_SQ1:
            begin
                mul_a = $signed({2'b00, ay});
                mul_b = $signed({2'b00, ay});
            end
            G_GATE:
            begin
                mul_a = $signed({{(MUL_W-SLOPE_W){1'b0}}, cfg.range_slope});
                mul_b = $signed({2'b00, root_reg[RANGE_W-1:0]});
            end
            G_SQG:
            begin
                mul_a = $signed({1'b0, gate_reg});
                mul_b = $signed({1'b0, gate_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE: if (start) state_next = G_ROT0;
            G_ROT0: state_next = G_ROT1;
            G_ROT1: state_next = G_ROT2;
            G_ROT2: state_next = G_ROT3;
            G_ROT3: state_next = G_SQ0;
            G_SQ0:  state_next = G_SQ1;
            G_SQ1:  state_next = G_ROOT;
            G_ROOT: if (bit_reg[0]) state_next = G_GATE;
            G_GATE: state_next = G_SQG;
            G_SQG:  state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == G_SQG);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    px_reg <= px;
                    py_reg <= py;
                end
            end
            G_ROT0: acc_x_reg <= ROT_W'(prod);
            G_ROT1: acc_x_reg <= acc_x_reg - ROT_W'(prod);
            G_ROT2: acc_y_reg <= ROT_W'(prod);
            G_ROT3: acc_y_reg <= acc_y_reg + ROT_W'(prod);
            G_SQ0:  rad_reg <= RAD_W'(prod);
            G_SQ1:
            begin
                rad_reg     <= rad_reg + RAD_W'(prod);
                root_reg    <= '0;
                bit_reg     <= RAD_W'(1) << (RAD_W - 2);
                geom_reg.qx <= Q_W'(acc_x_reg >>> FRAC_TRIG) + Q_W'(cfg.rel_dx);
                geom_reg.qy <= Q_W'(acc_y_reg >>> FRAC_TRIG) + Q_W'(cfg.rel_dy);
            end
            G_ROOT:
            begin
                if (rad_reg >= trial)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            G_GATE: gate_reg <= GATE_W'(cfg.base_threshold) + GATE_W'(prod >> FRAC_SLOPE);
            G_SQG:  geom_reg.gate2 <= GATE2_W'(prod);
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign geom = geom_reg;

endmodule
`default_nettype wire

// ===== rtl/grna_dist.sv =====
// Pipelined distance and gate compare for the map point at the head of the ring.
// Depends on grna_pkg.
`default_nettype none
module grna_dist (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire grna_pkg::geom_t                     geom,
    input  wire logic                               in_valid,
    input  wire logic [grna_pkg::IDX_W-1:0]          in_idx,
    input  wire logic signed [grna_pkg::COORD_W-1:0] mx,
    input  wire logic signed [grna_pkg::COORD_W-1:0] my,
    output logic                                     found,
    output logic [grna_pkg::IDX_W-1:0]               best_idx
);
    import grna_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        ex_reg, ey_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [D2_W-1:0]          d2, best_reg;
    logic                     v1_reg, v2_reg, found_reg;
    logic [IDX_W-1:0]         idx1_reg, idx2_reg, best_idx_reg;

    assign dx = DIFF_W'(geom.qx) - DIFF_W'(mx);
    assign dy = DIFF_W'(geom.qy) - DIFF_W'(my);
    assign d2 = D2_W'(sqx_reg) + D2_W'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            if (start)
            begin
                found_reg    <= 1'b0;
                best_idx_reg <= '0;
            end
            else if (v2_reg && (d2 < best_reg))
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= idx2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ey_reg   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        idx1_reg <= in_idx;
        sqx_reg  <= ex_reg * ex_reg;
        sqy_reg  <= ey_reg * ey_reg;
        idx2_reg <= idx1_reg;
        if (start)
            best_reg <= D2_W'(geom.gate2);
        else if (v2_reg && (d2 < best_reg))
            best_reg <= d2;
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule
`default_nettype wire

// ===== rtl/gated_nearest_reflector_association.sv =====
// Gated nearest reflector association: a query runs the shared-multiplier geometry with its
// 32-step square root, then one full turn of the map ring past the distance pipeline.
// One item is worked on at a time; a result waits in the output register, and the next
// result holds the block in ST_OUT until that register is taken.
// Asynchronous active-low reset empties the map and sets the registers to their defaults.
`default_nettype none
module gated_nearest_reflector_association (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_x[31:0], point_y[63:32], query_index[71:64]
    input  wire logic [grna_pkg::IN_DATA_W-1:0]       s_tdata,
    // cmd[1:0]
    input  wire logic [grna_pkg::CMD_W-1:0]           s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // observed_index[7:0], map_index[13:8], zero[15:14]
    output logic [grna_pkg::OUT_DATA_W-1:0]           m_tdata,
    // matched[0]
    output logic                                      m_tuser,
    input  wire logic                                 cfg_we,
    input  wire logic [grna_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [grna_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import grna_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_GEOM  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    cfg_t                      cfg_reg;
    logic [CNT_W-1:0]          map_count_reg, scan_cnt_reg;
    logic [1:0]                drain_cnt_reg;
    logic [QIDX_W-1:0]         qidx_reg;
    logic                      m_tvalid_reg, m_tuser_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    logic                      in_fire, load_fire, query_fire, clear_fire, out_load;
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic                      geom_done, found;
    geom_t                     geom;
    logic [IDX_W-1:0]          best_idx;

    logic signed [COORD_W-1:0] ring_x [MAP_DEPTH];
    logic signed [COORD_W-1:0] ring_y [MAP_DEPTH];

    assign cmd        = cmd_t'(s_tuser);
    assign in_x       = s_tdata[31:0];
    assign in_y       = s_tdata[63:32];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign load_fire  = in_fire && (cmd == CMD_LOAD) && (map_count_reg < CNT_W'(MAP_DEPTH));
    assign query_fire = in_fire && (cmd == CMD_QUERY);
    assign clear_fire = in_fire && (cmd == CMD_CLEAR);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    genvar k;
    generate
        for (k = 0; k < MAP_DEPTH; k++)
        begin : g_ring
            grna_cell u_cell (
                .clk      (clk),
                .shift_en (state_reg == ST_SCAN),
                .shift_x  (ring_x[(k + 1) % MAP_DEPTH]),
                .shift_y  (ring_y[(k + 1) % MAP_DEPTH]),
                .wr_en    (load_fire && (map_count_reg == CNT_W'(k))),
                .wr_x     (in_x),
                .wr_y     (in_y),
                .x        (ring_x[k]),
                .y        (ring_y[k])
            );
        end
    endgenerate

    grna_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (query_fire),
        .px    (in_x),
        .py    (in_y),
        .cfg   (cfg_reg),
        .done  (geom_done),
        .geom  (geom)
    );

    grna_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (geom_done),
        .geom     (geom),
        .in_valid ((state_reg == ST_SCAN) && (scan_cnt_reg < map_count_reg)),
        .in_idx   (scan_cnt_reg[IDX_W-1:0]),
        .mx       (ring_x[0]),
        .my       (ring_y[0]),
        .found    (found),
        .best_idx (best_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (query_fire) state_next = ST_GEOM;
            ST_GEOM:  if (geom_done) state_next = ST_SCAN;
            ST_SCAN:  if (scan_cnt_reg == CNT_W'(MAP_DEPTH - 1)) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_cnt_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= ST_IDLE;
            map_count_reg          <= '0;
            scan_cnt_reg           <= '0;
            drain_cnt_reg          <= '0;
            m_tvalid_reg           <= 1'b0;
            cfg_reg.rel_cos        <= 16'sd16384;
            cfg_reg.rel_sin        <= '0;
            cfg_reg.rel_dx         <= '0;
            cfg_reg.rel_dy         <= '0;
            cfg_reg.base_threshold <= 31'd13107;
            cfg_reg.range_slope    <= 16'd2287;
        end
        else
        begin
            state_reg <= state_next;

            if (load_fire)
                map_count_reg <= map_count_reg + 1'b1;
            else if (clear_fire)
                map_count_reg <= '0;

            if (state_reg == ST_SCAN)
                scan_cnt_reg <= (scan_cnt_reg == CNT_W'(MAP_DEPTH - 1)) ? '0
                                                                        : scan_cnt_reg + 1'b1;

            if (state_reg == ST_DRAIN)
                drain_cnt_reg <= drain_cnt_reg + 1'b1;
            else
                drain_cnt_reg <= '0;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REL_COS: cfg_reg.rel_cos        <= cfg_data[TRIG_W-1:0];
                    CFG_REL_SIN: cfg_reg.rel_sin        <= cfg_data[TRIG_W-1:0];
                    CFG_REL_DX:  cfg_reg.rel_dx         <= cfg_data[COORD_W-1:0];
                    CFG_REL_DY:  cfg_reg.rel_dy         <= cfg_data[COORD_W-1:0];
                    CFG_BASE:    cfg_reg.base_threshold <= cfg_data[BASE_W-1:0];
                    CFG_SLOPE:   cfg_reg.range_slope    <= cfg_data[SLOPE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
            qidx_reg <= s_tdata[71:64];
        if (out_load)
        begin
            m_tuser_reg <= found;
            m_tdata_reg <= {2'b00,
                            found ? MAP_INDEX_W'(best_idx) : MAP_INDEX_W'(0),
                            qidx_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ===== rtl/grna_checker.sv =====
// Port-level checks for the gated nearest reflector association block, bound to the top level.
// Depends on grna_pkg and gated_nearest_reflector_association.
`default_nettype none
module grna_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [grna_pkg::CMD_W-1:0]      s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [grna_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);
    import grna_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed or dropped while stalled.");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[13:8] == '0)
        else $error("Unmatched result carries a nonzero map index.");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("Result appeared without a query in progress.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_QUERY |=> !s_tready)
        else $error("Input taken while a query is being worked on.");

endmodule

bind gated_nearest_reflector_association grna_checker u_grna_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for gated_nearest_reflector_association: map loads, clears and gated queries
// are checked against an in-bench nearest-point predictor. Depends on rtl/grna_pkg.sv
// and rtl/gated_nearest_reflector_association.sv.
`timescale 1ns / 1ps
module tb;
    import grna_pkg::*;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0]         qidx;
        bit                 typed;
        logic               t_matched;
        logic [5:0]         t_map;
    } stim_row_t;

    typedef struct {
        logic       matched;
        logic [7:0] obs;
        logic [5:0] map;
    } assoc_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = CMD_NONE;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gated_nearest_reflector_association DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor copy of registers and map store.
    logic signed [15:0] p_cos = 16384, p_sin = 0;
    logic signed [31:0] p_dx = 0, p_dy = 0;
    logic [30:0] p_base = 13107;
    logic [15:0] p_slope = 2287;
    logic signed [31:0] map_xs [MAP_DEPTH];
    logic signed [31:0] map_ys [MAP_DEPTH];
    int map_n = 0;

    assoc_t pending_q [$];
    int errors = 0;
    int items_sent = 0;
    bit hold_rx = 1'b0;
    bit quiet = 1'b0;
    int rx_wait = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic assoc_t nearest_in_gate(logic signed [31:0] px, logic signed [31:0] py,
                                               logic [7:0] qidx);
        assoc_t r;
        longint c, s, qx, qy, ex, ey;
        longint unsigned ax, ay, n, res, b, range_q, gate;
        bit [127:0] g2, best, d2;
        c = p_cos;
        s = p_sin;
        qx = ((c * longint'(px) - s * longint'(py)) >>> 14) + longint'(p_dx);
        qy = ((s * longint'(px) + c * longint'(py)) >>> 14) + longint'(p_dy);
        ax = px < 0 ? -longint'(px) : longint'(px);
        ay = py < 0 ? -longint'(py) : longint'(py);
        n = ax * ax + ay * ay;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        range_q = res;
        gate = longint'(p_base) + ((longint'(p_slope) * range_q) >> 16);
        g2 = {64'b0, gate} * {64'b0, gate};
        best = g2;
        r.matched = 1'b0;
        r.obs = qidx;
        r.map = '0;
        for (int j = 0; j < map_n; j++) begin
            ex = qx - longint'(map_xs[j]);
            ey = qy - longint'(map_ys[j]);
            if (ex < 0) ex = -ex;
            if (ey < 0) ey = -ey;
            d2 = {64'b0, ex} * {64'b0, ex} + {64'b0, ey} * {64'b0, ey};
            if (d2 < best) begin
                best = d2;
                r.matched = 1'b1;
                r.map = j[5:0];
            end
        end
        return r;
    endfunction

    task automatic send(stim_row_t it);
        int g;
        assoc_t a;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {it.qidx, it.y, it.x};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        case (it.cmd)
            CMD_LOAD: begin
                if (map_n < MAP_DEPTH) begin
                    map_xs[map_n] = it.x;
                    map_ys[map_n] = it.y;
                    map_n++;
                end
            end
            CMD_CLEAR: map_n = 0;
            CMD_QUERY: begin
                a = nearest_in_gate(it.x, it.y, it.qidx);
                if (it.typed) begin
                    a.matched = it.t_matched;
                    a.map = it.t_map;
                end
                pending_q = {pending_q, a};
            end
            default: ;
        endcase
    endtask

    task automatic item(cmd_t c, logic [31:0] x, logic [31:0] y, logic [7:0] q);
        stim_row_t it;
        it = '{c, x, y, q, 1'b0, 1'b0, 6'd0};
        send(it);
    endtask

    // Let the block finish and every result arrive before touching the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_REL_COS: p_cos = val[15:0];
            CFG_REL_SIN: p_sin = val[15:0];
            CFG_REL_DX:  p_dx = val;
            CFG_REL_DY:  p_dy = val;
            CFG_BASE:    p_base = val[30:0];
            CFG_SLOPE:   p_slope = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(logic [15:0] c, logic [15:0] s, logic [31:0] dx, logic [31:0] dy,
                           logic [31:0] base, logic [15:0] slope);
        write_reg(CFG_REL_COS, {16'($urandom_range(0, 65535)), c});
        write_reg(CFG_REL_SIN, {16'hffff, s});
        write_reg(CFG_REL_DX, dx);
        write_reg(CFG_REL_DY, dy);
        write_reg(CFG_BASE, base);
        write_reg(CFG_SLOPE, {16'($urandom_range(0, 65535)), slope});
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        assoc_t e;
        int g;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata=%h tuser=%b",
                       m_tdata, m_tuser);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_tuser !== e.matched) begin
                    $error("matched: expected %0d, got %0d", e.matched, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== e.obs) begin
                    $error("observed_index: expected %0d, got %0d", e.obs, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[13:8] !== e.map) begin
                    $error("map_index: expected %0d, got %0d", e.map, m_tdata[13:8]);
                    errors++;
                end
            end
        end
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                rx_wait = g - 1;
                m_tready <= 1'b0;
            end
        end
    end

    // Long receiver stall while the sender keeps offering queries.
    initial begin
        wait (items_sent >= 300);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (500) @(posedge clk);
        hold_rx = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    stim_row_t directed [18] = '{
        '{CMD_QUERY, 32'sd0, 32'sd0, 8'd0, 1'b1, 1'b0, 6'd0},
        '{CMD_LOAD, 32'sd0, 32'sd0, 8'd0, 1'b0, 1'b0, 6'd0},
        '{CMD_LOAD, 32'sd65536, 32'sd0, 8'd0, 1'b0, 1'b0, 6'd0},
        '{CMD_LOAD, 32'sd0, 32'sd0, 8'd0, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'sd0, 32'sd0, 8'd255, 1'b1, 1'b1, 6'd0},
        '{CMD_QUERY, 32'sd65536, 32'sd100, 8'd1, 1'b1, 1'b1, 6'd1},
        '{CMD_QUERY, 32'sd32768, 32'sd0, 8'd2, 1'b1, 1'b0, 6'd0},
        '{CMD_LOAD, 32'h7fffffff, 32'h80000000, 8'hff, 1'b0, 1'b0, 6'd0},
        '{CMD_LOAD, 32'h80000000, 32'h7fffffff, 8'h00, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'h7fffffff, 32'h80000000, 8'd3, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'h80000000, 32'h80000000, 8'd4, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'h80000000, 32'h7fffffff, 8'd5, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'hffffffff, 32'hffffffff, 8'd6, 1'b0, 1'b0, 6'd0},
        '{CMD_NONE, 32'sd0, 32'sd0, 8'd7, 1'b0, 1'b0, 6'd0},
        '{CMD_CLEAR, 32'sd0, 32'sd0, 8'd0, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'sd0, 32'sd0, 8'd8, 1'b1, 1'b0, 6'd0},
        '{CMD_LOAD, 32'sd1000, 32'sd1000, 8'd0, 1'b0, 1'b0, 6'd0},
        '{CMD_QUERY, 32'sd1000, 32'sd1000, 8'd170, 1'b1, 1'b1, 6'd0}
    };

    initial begin
        int n_loads, n_queries, j, kind, ru, cu, su, g;
        logic signed [31:0] tx, ty, dx, dy;
        logic [31:0] base;
        logic [15:0] cv, sv;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        foreach (directed[i]) send(directed[i]);
        // Fill past the depth so the extra loads are dropped.
        for (int i = 0; i < 70; i++)
            item(CMD_LOAD, $urandom_range(0, 200) << 12, $urandom_range(0, 200) << 12, 8'd0);
        for (int i = 0; i < 4; i++)
            item(CMD_QUERY, $urandom_range(0, 200) << 12, $urandom_range(0, 200) << 12, 8'(i));

        while (items_sent < 1000) begin
            drain();
            quiet = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            ru = $urandom_range(0, 3);
            cu = (ru == 0) ? 1 : (ru == 2) ? -1 : 0;
            su = (ru == 1) ? 1 : (ru == 3) ? -1 : 0;
            if (kind < 7) begin
                cv = 16'(cu * 16384);
                sv = 16'(su * 16384);
                dx = $signed($urandom) >>> 2;
                dy = $signed($urandom) >>> 2;
                base = $urandom_range(1000, 200000);
            end else begin
                cv = (kind == 7) ? 16'sd16384 : (kind == 8) ? -16'sd16384 : 16'($urandom);
                sv = (kind == 7) ? -16'sd16384 : 16'($urandom);
                dx = (kind == 7) ? 32'h7fffffff : (kind == 8) ? 32'h80000000 : $urandom;
                dy = (kind == 7) ? 32'h80000000 : (kind == 8) ? 32'h7fffffff : $urandom;
                base = (kind == 7) ? 32'h7fffffff : (kind == 8) ? 32'h0 : $urandom;
            end
            set_cfg(cv, sv, dx, dy, base,
                    (kind == 7) ? 16'hffff : (kind == 8) ? 16'h0 : 16'($urandom));
            if ($urandom_range(0, 2) != 0) item(CMD_CLEAR, $urandom, $urandom, 8'($urandom));
            n_loads = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 72)
                                                  : $urandom_range(1, 12);
            for (int i = 0; i < n_loads; i++) begin
                if (kind < 7)
                    item(CMD_LOAD, $signed($urandom) >>> 8, $signed($urandom) >>> 8,
                         8'($urandom));
                else
                    item(CMD_LOAD, $urandom, $urandom, 8'($urandom));
            end
            n_queries = $urandom_range(20, 60);
            for (int i = 0; i < n_queries; i++) begin
                if (kind < 7 && map_n > 0 && $urandom_range(0, 9) < 8) begin
                    j = $urandom_range(0, map_n - 1);
                    g = int'(p_base);
                    tx = map_xs[j] - dx + ($urandom_range(0, 2 * g) - g);
                    ty = map_ys[j] - dy + ($urandom_range(0, 2 * g) - g);
                    item(CMD_QUERY, cu * tx + su * ty, -su * tx + cu * ty, 8'($urandom));
                end else begin
                    case ($urandom_range(0, 19))
                        0: item(CMD_NONE, $urandom, $urandom, 8'($urandom));
                        1: item(CMD_LOAD, $urandom, $urandom, 8'($urandom));
                        default: item(CMD_QUERY, $urandom, $urandom, 8'($urandom));
                    endcase
                end
            end
        end
        // Sender pause until every result is back, then final idle time.
        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/grna_pkg.sv
rtl/grna_cell.sv
rtl/grna_geom.sv
rtl/grna_dist.sv
rtl/gated_nearest_reflector_association.sv
rtl/grna_checker.sv
tb/tb.sv
